// ===== rtl/close_point_decimator_stop_mark_defines.svh =====
// assertion macros for the close point decimator
// no dependencies; included by the decimator top level, which checks itself
`ifndef CLOSE_POINT_DECIMATOR_STOP_MARK_DEFINES_SVH
`define CLOSE_POINT_DECIMATOR_STOP_MARK_DEFINES_SVH

// same-cycle implication
`define CPDSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpdsm: same-cycle check failed");

// next-cycle implication
`define CPDSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpdsm: next-cycle check failed");

`endif

// ===== rtl/cpdsm_pkg.sv =====
// shared constants and beat types for the close point decimator
// no dependencies
package cpdsm_pkg;

    localparam int unsigned COORD_W        = 32;
    localparam int unsigned CFG_W          = 16;
    localparam int unsigned IDX_W          = 10;
    localparam int unsigned GAP_W          = 16;
    localparam int unsigned SQ_W           = 2 * GAP_W;
    localparam int unsigned MAX_POINTS_DEF = 1024;

    localparam logic [CFG_W-1:0] MIN_DIST_RESET = CFG_W'(100);
    localparam logic [SQ_W-1:0]  MIN_SQ_RESET   = SQ_W'(100 * 100);

    typedef struct packed {
        logic               first_point;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
    } t_in_beat;

    typedef struct packed {
        logic               kept;
        logic [IDX_W-1:0]   slot_index;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic               stop_mark;
        logic [IDX_W-1:0]   stop_index;
        logic               overflow;
    } t_out_beat;

endpackage

// ===== rtl/cpdsm_in_if.sv =====
// input point channel: valid/ready plus point payload
// depends on cpdsm_pkg
interface cpdsm_in_if;
    import cpdsm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      first_point;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;

    modport source (output valid, first_point, pos_x, pos_y, input ready);
    modport sink   (input valid, first_point, pos_x, pos_y, output ready);
endinterface

// ===== rtl/cpdsm_out_if.sv =====
// result channel: valid/ready plus decimation result payload
// depends on cpdsm_pkg
interface cpdsm_out_if;
    import cpdsm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      kept;
    logic [IDX_W-1:0]          slot_index;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      stop_mark;
    logic [IDX_W-1:0]          stop_index;
    logic                      overflow;

    modport source (output valid, kept, slot_index, out_x, out_y, stop_mark, stop_index,
                    overflow, input ready);
    modport sink   (input valid, kept, slot_index, out_x, out_y, stop_mark, stop_index,
                    overflow, output ready);
endinterface

// ===== rtl/close_point_decimator_stop_mark.sv =====
// close point decimator top level: distance check, slot and stop-mark tracking
// depends on cpdsm_pkg, cpdsm_in_if, cpdsm_out_if and the defines header
//
// i_in carries one path point per beat (first_point, pos_x, pos_y); o_out returns
// exactly one result beat per point, in order: kept flag, slot, kept coordinates,
// stop-candidate mark and the sticky overflow flag.
// i_cfg_we / i_cfg_wdata write the minimum spacing in mm; the squared value is
// registered on the write, so write it only while no beats are in flight.
// A point is captured in an input register, decided from that register against the
// last kept point (two 16x16 squarings, an add and a compare), and its result is
// registered in the result register.
// Throughput is one point per cycle unless o_out stalls: state is updated in the
// same cycle that the result register loads, so the next point sees it immediately.
// When o_out stalls, the result register holds and the input register fills; i_in
// ready drops only once both are occupied.
// Reset (synchronous, active low) empties both registers, sets the anchor to (0,0),
// slot and marks to 0, clears overflow and loads a minimum spacing of 100 mm.
`include "close_point_decimator_stop_mark_defines.svh"

module close_point_decimator_stop_mark #(
    parameter int unsigned MAX_POINTS = cpdsm_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cpdsm_pkg::CFG_W-1:0]   i_cfg_wdata,
    cpdsm_in_if.sink                      i_in,
    cpdsm_out_if.source                   o_out
);
    import cpdsm_pkg::*;

    localparam int unsigned SLOT_W     = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned SLOT_EXT_W = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_POINTS - 1);

    logic [SQ_W-1:0]    r_min_sq;
    logic [SQ_W-1:0]    n_min_sq;
    t_in_beat           r_in;
    logic               r_in_valid;
    t_out_beat          r_out;
    t_out_beat          n_out;
    logic               r_out_valid;
    logic [COORD_W-1:0] r_anchor_x;
    logic [COORD_W-1:0] r_anchor_y;
    logic [SLOT_W-1:0]  r_kept_slot;
    logic [SLOT_W-1:0]  n_kept_slot;
    logic [SLOT_W-1:0]  r_marked_slot;
    logic [SLOT_W-1:0]  n_marked_slot;
    logic               r_ovf;
    logic               n_ovf;

    logic               in_acc;
    logic               adv;
    logic [COORD_W:0]   dx;
    logic [COORD_W:0]   dy;
    logic [COORD_W:0]   dx_mag;
    logic [COORD_W:0]   dy_mag;
    logic               far;
    logic [SQ_W-1:0]    sq_x;
    logic [SQ_W-1:0]    sq_y;
    logic [SQ_W:0]      d2;
    logic               n_keep;
    logic               n_mark;
    logic               at_last;
    logic [SLOT_EXT_W-1:0] slot_ext;
    logic [SLOT_EXT_W-1:0] mark_ext;

    // handshake
    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;
    assign in_acc     = i_in.valid && i_in.ready;

    assign n_min_sq = i_cfg_wdata * i_cfg_wdata;

    // distance check
    assign dx     = {r_in.pos_x[COORD_W-1], r_in.pos_x} - {r_anchor_x[COORD_W-1], r_anchor_x};
    assign dy     = {r_in.pos_y[COORD_W-1], r_in.pos_y} - {r_anchor_y[COORD_W-1], r_anchor_y};
    assign dx_mag = dx[COORD_W] ? (~dx + (COORD_W+1)'(1)) : dx;
    assign dy_mag = dy[COORD_W] ? (~dy + (COORD_W+1)'(1)) : dy;
    assign far    = (|dx_mag[COORD_W:GAP_W]) || (|dy_mag[COORD_W:GAP_W]);
    assign sq_x   = dx_mag[GAP_W-1:0] * dx_mag[GAP_W-1:0];
    assign sq_y   = dy_mag[GAP_W-1:0] * dy_mag[GAP_W-1:0];
    assign d2     = {1'b0, sq_x} + {1'b0, sq_y};
    assign n_keep = r_in.first_point || far || (d2 >= {1'b0, r_min_sq});

    // slot, stop mark and overflow tracking
    assign at_last = (r_kept_slot == SLOT_LAST);
    assign n_mark  = !r_in.first_point && !n_keep && (r_kept_slot != r_marked_slot);

    always_comb begin
        n_kept_slot   = r_kept_slot;
        n_marked_slot = r_marked_slot;
        n_ovf         = r_ovf;
        if (r_in.first_point) begin
            n_kept_slot   = '0;
            n_marked_slot = '0;
            n_ovf         = 1'b0;
        end else if (n_keep) begin
            if (at_last) begin
                n_ovf = 1'b1;
            end else begin
                n_kept_slot = r_kept_slot + SLOT_W'(1);
            end
        end else if (n_mark) begin
            n_marked_slot = r_kept_slot;
        end
    end

    assign slot_ext = SLOT_EXT_W'(n_kept_slot);
    assign mark_ext = SLOT_EXT_W'(r_kept_slot);

    always_comb begin
        n_out.kept       = n_keep;
        n_out.slot_index = slot_ext[IDX_W-1:0];
        n_out.out_x      = n_keep ? r_in.pos_x : '0;
        n_out.out_y      = n_keep ? r_in.pos_y : '0;
        n_out.stop_mark  = n_mark;
        n_out.stop_index = n_mark ? mark_ext[IDX_W-1:0] : '0;
        n_out.overflow   = n_ovf;
    end

    // control and path state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_sq      <= MIN_SQ_RESET;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_anchor_x    <= '0;
            r_anchor_y    <= '0;
            r_kept_slot   <= '0;
            r_marked_slot <= '0;
            r_ovf         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_sq <= n_min_sq;
            end
            r_in_valid  <= in_acc || (r_in_valid && !adv);
            r_out_valid <= adv || (r_out_valid && !o_out.ready);
            if (adv) begin
                r_kept_slot   <= n_kept_slot;
                r_marked_slot <= n_marked_slot;
                r_ovf         <= n_ovf;
                if (n_keep) begin
                    r_anchor_x <= r_in.pos_x;
                    r_anchor_y <= r_in.pos_y;
                end
            end
        end
    end

    // beat payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.first_point <= i_in.first_point;
            r_in.pos_x       <= i_in.pos_x;
            r_in.pos_y       <= i_in.pos_y;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kept       = r_out.kept;
    assign o_out.slot_index = r_out.slot_index;
    assign o_out.out_x      = r_out.out_x;
    assign o_out.out_y      = r_out.out_y;
    assign o_out.stop_mark  = r_out.stop_mark;
    assign o_out.stop_index = r_out.stop_index;
    assign o_out.overflow   = r_out.overflow;

    `CPDSM_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !adv, r_in_valid)
    `CPDSM_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, adv, r_out_valid)
    `CPDSM_ASSERT_NOW(a_mark_not_slot0, i_clk, i_rst_n, adv && n_mark, r_kept_slot != '0)
    `CPDSM_ASSERT_NOW(a_mark_on_drop, i_clk, i_rst_n, adv && n_mark, !n_keep)
    `CPDSM_ASSERT_NEXT(a_slot_step, i_clk, i_rst_n,
        adv && n_keep && !r_in.first_point && !at_last,
        r_kept_slot == $past(r_kept_slot) + SLOT_W'(1))

endmodule

// ===== verif/tb_close_point_decimator_stop_mark.sv =====
// self-checking bench for close_point_decimator_stop_mark: directed and random path points,
// every result beat compared with a cycle-free prediction of the decimator
// depends on cpdsm_pkg, cpdsm_in_if, cpdsm_out_if and the rtl top level
module tb_close_point_decimator_stop_mark;
    import cpdsm_pkg::*;

    localparam int          HALF_PERIOD = 5;
    localparam int unsigned MAX_PTS     = MAX_POINTS_DEF;
    localparam longint      FAR_GAP     = 65536;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 150;

    typedef enum int {RX_OPEN, RX_COIN, RX_EVERY4, RX_MOSTLY} t_rx_mode;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    cpdsm_in_if  pt_if();
    cpdsm_out_if res_if();

    close_point_decimator_stop_mark #(.MAX_POINTS(MAX_PTS)) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in       (pt_if.sink),
        .o_out      (res_if.source)
    );

    always #HALF_PERIOD clk = ~clk;

    // decimator state as seen by the bench
    logic [CFG_W-1:0]          min_mm;
    logic signed [COORD_W-1:0] last_kept_x;
    logic signed [COORD_W-1:0] last_kept_y;
    int unsigned               kept_slot_ctr;
    int unsigned               marked_slot_ctr;
    logic                      overflow_flag;

    t_in_beat  pts_to_send[$];
    t_out_beat expected_results[$];
    t_in_beat  in_flight;
    int        fail_count;
    int        cycle_count;
    int        burst_left;
    int        gap_left;
    int        hold_asks;
    int        hold_taken;
    int        hold_left;
    int        rx_tick;
    t_rx_mode  rx_mode;

    function automatic t_out_beat decide_point(t_in_beat p);
        t_out_beat r;
        longint    dx;
        longint    dy;
        longint    ax;
        longint    ay;
        logic      keep;
        r = '0;
        if (p.first_point) begin
            kept_slot_ctr   = 0;
            marked_slot_ctr = 0;
            overflow_flag   = 1'b0;
            keep            = 1'b1;
        end else begin
            dx = longint'($signed(p.pos_x)) - longint'(last_kept_x);
            dy = longint'($signed(p.pos_y)) - longint'(last_kept_y);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            if (ax >= FAR_GAP || ay >= FAR_GAP)
                keep = 1'b1;
            else
                keep = (ax * ax + ay * ay) >= longint'(min_mm) * longint'(min_mm);
            if (keep) begin
                if (kept_slot_ctr < MAX_PTS - 1)
                    kept_slot_ctr++;
                else
                    overflow_flag = 1'b1;
            end else if (kept_slot_ctr != marked_slot_ctr) begin
                r.stop_mark     = 1'b1;
                r.stop_index    = IDX_W'(kept_slot_ctr);
                marked_slot_ctr = kept_slot_ctr;
            end
        end
        if (keep) begin
            last_kept_x = p.pos_x;
            last_kept_y = p.pos_y;
            r.out_x     = p.pos_x;
            r.out_y     = p.pos_y;
        end
        r.kept       = keep;
        r.slot_index = IDX_W'(kept_slot_ctr);
        r.overflow   = overflow_flag;
        return r;
    endfunction

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    // point driver: bursts of beats with random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            pt_if.valid <= 1'b0;
            burst_left  = $urandom_range(1, 48);
            gap_left    = 0;
        end else begin
            if (pt_if.valid && pt_if.ready)
                expected_results.insert(expected_results.size(), decide_point(in_flight));
            if (!pt_if.valid || pt_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    pt_if.valid <= 1'b0;
                end else if (pts_to_send.size() > 0) begin
                    in_flight = pts_to_send.pop_front();
                    pt_if.valid       <= 1'b1;
                    pt_if.first_point <= in_flight.first_point;
                    pt_if.pos_x       <= in_flight.pos_x;
                    pt_if.pos_y       <= in_flight.pos_y;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    pt_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and ready pattern
    always @(posedge clk) begin : result_mon
        t_out_beat want;
        logic      rdy;
        if (!rst_n) begin
            res_if.ready <= 1'b0;
            rx_tick    = 0;
            rx_mode    = RX_OPEN;
            hold_left  = 0;
            hold_taken = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with nothing expected", $time);
                end else begin
                    want = expected_results.pop_front();
                    check_field("kept", 32'(want.kept), 32'(res_if.kept));
                    check_field("slot_index", 32'(want.slot_index), 32'(res_if.slot_index));
                    check_field("out_x", want.out_x, res_if.out_x);
                    check_field("out_y", want.out_y, res_if.out_y);
                    check_field("stop_mark", 32'(want.stop_mark), 32'(res_if.stop_mark));
                    check_field("stop_index", 32'(want.stop_index), 32'(res_if.stop_index));
                    check_field("overflow", 32'(want.overflow), 32'(res_if.overflow));
                end
            end
            rx_tick++;
            if (rx_tick % 50 == 0)
                rx_mode = t_rx_mode'($urandom_range(0, 3));
            if (hold_asks != hold_taken && hold_left == 0) begin
                hold_taken++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:   rdy = 1'b1;
                    RX_COIN:   rdy = 1'($urandom_range(0, 1));
                    RX_EVERY4: rdy = (rx_tick % 4 == 0);
                    default:   rdy = ($urandom_range(0, 7) != 0);
                endcase
            end
            res_if.ready <= rdy;
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_point(logic first, logic [31:0] x, logic [31:0] y);
        t_in_beat p;
        p.first_point = first;
        p.pos_x       = x;
        p.pos_y       = y;
        pts_to_send.insert(pts_to_send.size(), p);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pts_to_send.size() != 0 || pt_if.valid || expected_results.size() != 0);
    endtask

    task automatic set_min_spacing(logic [CFG_W-1:0] v);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        min_mm = v;
        @(negedge clk);
    endtask

    function automatic logic [31:0] start_coord();
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // paths that start with a first point and walk around the spacing, plus noise beats
    task automatic random_paths(int n_items);
        int          done_cnt;
        int          pick;
        int          span;
        int          step;
        logic [31:0] x;
        logic [31:0] y;
        span     = 2 * int'(min_mm) + 4;
        done_cnt = 0;
        while (done_cnt < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_point(1'($urandom_range(0, 1)), $urandom, $urandom);
                done_cnt++;
            end else begin
                x = start_coord();
                y = start_coord();
                queue_point(1'b1, x, y);
                done_cnt++;
                repeat ($urandom_range(1, 24)) begin
                    pick = $urandom_range(0, 15);
                    if (pick == 0) begin
                        x = $urandom;
                        y = $urandom;
                    end else if (pick >= 8) begin
                        x = x + 32'(int'($urandom_range(0, 2 * span)) - span);
                        y = y + 32'(int'($urandom_range(0, 2 * span)) - span);
                    end else if (pick >= 4) begin
                        // one axis stepped right around the spacing
                        step = int'(min_mm) + int'($urandom_range(0, 2)) - 1;
                        if ($urandom_range(0, 1))
                            step = -step;
                        if ($urandom_range(0, 1))
                            x = x + 32'(step);
                        else
                            y = y + 32'(step);
                    end
                    // remaining picks repeat the last point
                    queue_point(1'b0, x, y);
                    done_cnt++;
                end
            end
        end
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] spacings[7];
        logic [31:0]      x;
        logic [31:0]      y;
        pt_if.valid       = 1'b0;
        pt_if.first_point = 1'b0;
        pt_if.pos_x       = '0;
        pt_if.pos_y       = '0;
        res_if.ready      = 1'b0;
        fail_count        = 0;
        cycle_count       = 0;
        hold_asks         = 0;
        min_mm            = MIN_DIST_RESET;
        last_kept_x       = '0;
        last_kept_y       = '0;
        kept_slot_ctr     = 0;
        marked_slot_ctr   = 0;
        overflow_flag     = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no path started, exact spacing, marks once per slot, extreme coordinates
        queue_point(1'b0, 32'd0, 32'd0);
        queue_point(1'b0, 32'd60, 32'd80);
        queue_point(1'b0, 32'd60, 32'd79);
        queue_point(1'b0, 32'd0, 32'd0);
        queue_point(1'b0, 32'd99, 32'd0);
        queue_point(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_point(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_point(1'b0, 32'h8000_0000, 32'h8000_0000);
        queue_point(1'b0, 32'h8000_FFFF, 32'h8000_0000);
        queue_point(1'b0, 32'h8000_0000, 32'h8000_0000);
        queue_point(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_point(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_point(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_point(1'b1, 32'd0, 32'd0);
        queue_point(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // widest spacing: equal distance, sum wider than 32 bits, far gap
        set_min_spacing(16'hFFFF);
        queue_point(1'b1, 32'd0, 32'd0);
        queue_point(1'b0, 32'd65534, 32'd0);
        queue_point(1'b0, 32'd65535, 32'd0);
        queue_point(1'b0, 32'd131070, 32'd65535);
        queue_point(1'b0, 32'd131069, 32'd65535);
        queue_point(1'b0, 32'd65535, 32'd65535);
        queue_point(1'b0, 32'd65535, 32'hFFFF_FFFF);

        // zero spacing keeps every point
        set_min_spacing(16'd0);
        queue_point(1'b1, 32'd5, 32'd5);
        queue_point(1'b0, 32'd5, 32'd5);
        queue_point(1'b0, 32'd5, 32'd5);

        spacings = '{16'd1, 16'd7, 16'd100, 16'd1000, 16'hFFFF, 16'd0, 16'($urandom)};
        for (int i = 0; i < 7; i++) begin
            set_min_spacing(spacings[i]);
            random_paths(85);
            if (i == 1 || i == 4)
                hold_asks++;
        end

        // one long path with repeated points for stop marks
        set_min_spacing(16'd1);
        x = $urandom;
        y = $urandom;
        queue_point(1'b1, x, y);
        for (int i = 0; i < 230; i++) begin
            if (i % 40 != 39)
                x = x + 32'd1;
            queue_point(1'b0, x, y);
        end
        hold_asks++;
        queue_point(1'b1, $urandom, $urandom);
        queue_point(1'b0, $urandom, $urandom);

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
